@@ rtl/assert_macros.svh @@
// Assertion macros used by the interrupt controller core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: always condition");

// Antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/fpic_pkg.sv @@
package fpic_pkg;

	localparam int NUM_LINES = 8;
	localparam int LINE_W    = 3;
	localparam int VEC_W     = 8;

	// reset values of the configuration registers
	localparam logic [NUM_LINES-1:0] MASK_RESET = 8'hFF;
	localparam logic [VEC_W-1:0]     BASE_RESET = 8'h20;

	// operation codes of an input item
	typedef enum logic [1:0] {
		MODE_RAISE = 2'd0,
		MODE_ACK   = 2'd1,
		MODE_EOI   = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic {
		CFG_IRQ_MASK = 1'b0,
		CFG_VEC_BASE = 1'b1
	} cfg_idx_t;

	// one result item
	typedef struct packed {
		logic                 vector_valid;
		logic [VEC_W-1:0]     vector;
		logic [NUM_LINES-1:0] requests_now;
		logic [NUM_LINES-1:0] in_service_now;
	} result_t;

	// grant information from the priority logic
	typedef struct packed {
		logic                 found;
		logic [LINE_W-1:0]    idx;
		logic [NUM_LINES-1:0] onehot;
	} grant_t;

endpackage

@@ rtl/fpic_prio_enc.sv @@
module fpic_prio_enc
	import fpic_pkg::*;
(
	input  logic [NUM_LINES-1:0] pending,
	output grant_t               grant
);

	// lowest-numbered set bit wins: scan from the top so lower lines overwrite
	always_comb begin
		grant.found  = 1'b0;
		grant.idx    = '0;
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (pending[i]) begin
				grant.found = 1'b1;
				grant.idx   = LINE_W'(i);
			end
		end
		grant.onehot = grant.found ? (NUM_LINES'(1) << grant.idx) : '0;
	end

endmodule

@@ rtl/fpic_state.sv @@
module fpic_state
	import fpic_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_wr_en,
	input  logic                 cfg_addr,
	input  logic [VEC_W-1:0]     cfg_wdata,
	// item being processed
	input  logic                 fire,
	input  logic [1:0]           mode,
	input  logic [LINE_W-1:0]    line,
	// result of that item
	output result_t              res,
	output grant_t               grant
);

	logic [NUM_LINES-1:0] irq_mask_q;
	logic [VEC_W-1:0]     vec_base_q;
	logic [NUM_LINES-1:0] req_q;
	logic [NUM_LINES-1:0] isr_q;

	logic [NUM_LINES-1:0] pending;
	logic [NUM_LINES-1:0] line_bit;
	logic [NUM_LINES-1:0] req_nxt;
	logic [NUM_LINES-1:0] isr_nxt;

	// unmasked pending lines
	assign pending  = req_q & ~irq_mask_q;
	assign line_bit = NUM_LINES'(1) << line;

	fpic_prio_enc u_prio (
		.pending (pending),
		.grant   (grant)
	);

	// register update and result for the current item
	always_comb begin
		req_nxt          = req_q;
		isr_nxt          = isr_q;
		res.vector_valid = 1'b0;
		res.vector       = '0;
		unique case (mode)
			MODE_RAISE: begin
				req_nxt = req_q | line_bit;
			end
			MODE_ACK: begin
				if (grant.found) begin
					req_nxt          = req_q & ~grant.onehot;
					isr_nxt          = isr_q | grant.onehot;
					res.vector_valid = 1'b1;
					res.vector       = vec_base_q + VEC_W'(grant.idx);
				end
			end
			MODE_EOI: begin
				isr_nxt = isr_q & ~line_bit;
			end
			default: begin
				// undefined code: no change
			end
		endcase
		res.requests_now   = req_nxt;
		res.in_service_now = isr_nxt;
	end

	// request and in-service registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			isr_q <= '0;
		end else if (fire) begin
			req_q <= req_nxt;
			isr_q <= isr_nxt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_mask_q <= MASK_RESET;
			vec_base_q <= BASE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_IRQ_MASK: irq_mask_q <= cfg_wdata;
				CFG_VEC_BASE: vec_base_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

endmodule

@@ rtl/fixed_priority_interrupt_controller_core.sv @@
// Eight-line fixed-priority interrupt controller. Each input item raises a
// request, acknowledges the lowest-numbered unmasked pending line, or ends
// service of a line, and produces exactly one result item carrying the
// granted vector (vector base + line, mod 256) and both state registers.
// An item is registered in the input register on acceptance, and its result
// is registered in the result register when that register is free or drained;
// one item is accepted every cycle while the receiver does not stall.
// While a stalled receiver holds the result register, one more item is
// taken into the input register and the input then stalls until the result
// is accepted. Write irq_mask and the vector base only while the block is idle.
`include "assert_macros.svh"

module fixed_priority_interrupt_controller_core
	import fpic_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port: index 0 irq_mask, index 1 vector base
	input  logic                 cfg_wr_en,
	input  logic                 cfg_addr,
	input  logic [VEC_W-1:0]     cfg_wdata,
	// input items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [1:0] mode, [4:2] line, [7:5] zero
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata   // [0] vector_valid, [8:1] vector,
	                                            // [16:9] requests_now,
	                                            // [24:17] in_service_now, [31:25] zero
);

	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [LINE_W-1:0]    line_s1;
	logic                 out_valid_q;
	result_t              res_q;

	logic                 s_fire;
	logic                 advance;
	result_t              res_now;
	grant_t               grant;

	// stage 1 moves into the result register when that register is free or drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_s1 <= s_axis_tdata[1:0];
			line_s1 <= s_axis_tdata[4:2];
		end
	end

	fpic_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fire      (advance),
		.mode      (mode_s1),
		.line      (line_s1),
		.res       (res_now),
		.grant     (grant)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_now;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, res_q.in_service_now, res_q.requests_now,
	                        res_q.vector, res_q.vector_valid};

	// at most one line granted per item
	`ASSERT_ALWAYS(a_grant_onehot, clk, arst_n, $onehot0(grant.onehot))
	// an item leaving stage 1 always lands in the result register
	`ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, out_valid_q)
	// a granted line shows in service and no longer requested
	`ASSERT_NEXT(a_grant_isr, clk, arst_n, advance && res_now.vector_valid,
		(res_q.in_service_now & $past(grant.onehot)) == $past(grant.onehot))
	`ASSERT_NEXT(a_grant_req_clr, clk, arst_n, advance && res_now.vector_valid,
		(res_q.requests_now & $past(grant.onehot)) == '0)

endmodule
